// File: rtl/sdspi_pkg.sv
// Shared types, codes and constants for the SD card SPI-mode host sequencer.
// No dependencies; imported by sd_spi_host_sequencer.
package sdspi_pkg;

  localparam int BLOCK_BYTES      = 512;
  localparam int IDLE_CLOCK_BYTES = 10;
  localparam int BLOCK_IDX_W      = $clog2(BLOCK_BYTES + 1);
  localparam int OCR_BYTES        = 4;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_READ   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_WDATA  = 3'd3,
    ACT_REPLY  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_DRIVE  = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_RDATA  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ERROR  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_R1_POLL_LIMIT    = 2'd0,
    CFG_INIT_RETRY_LIMIT = 2'd1,
    CFG_TOKEN_WAIT_LIMIT = 2'd2
  } cfg_index_t;

  localparam logic [7:0]  R1_POLL_RESET    = 8'd8;
  localparam logic [15:0] INIT_RETRY_RESET = 16'd255;
  localparam logic [15:0] TOKEN_WAIT_RESET = 16'hFFFF;

  localparam logic [5:0]  CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0]  CMD_IF_COND   = 6'd8;
  localparam logic [5:0]  CMD_READ_BLK  = 6'd17;
  localparam logic [5:0]  CMD_WRITE_BLK = 6'd24;
  localparam logic [5:0]  CMD_SD_OP     = 6'd41;
  localparam logic [5:0]  CMD_APP       = 6'd55;

  localparam logic [7:0]  CMD_BASE      = 8'h40;
  localparam logic [7:0]  CRC_DEFAULT   = 8'h95;
  localparam logic [7:0]  CRC_IF_COND   = 8'h87;
  localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
  localparam logic [31:0] ARG_SD_OP     = 32'h4000_0000;
  localparam logic [7:0]  DATA_TOKEN    = 8'hFE;
  localparam logic [4:0]  RESP_MASK     = 5'h1F;
  localparam logic [4:0]  RESP_ACCEPT   = 5'h05;
  localparam logic [7:0]  R1_BUSY_MASK  = 8'h80;
  localparam logic [7:0]  R1_IDLE       = 8'h01;
  localparam logic [7:0]  R1_READY      = 8'h00;
  localparam logic [7:0]  FILL_BYTE     = 8'hFF;

  // Result bursts caused by one input beat
  typedef enum logic [3:0] {
    B_REJECT,
    B_INIT,
    B_CMD,
    B_POLL,
    B_FINISH,
    B_DRIVE,
    B_WR_LAST,
    B_RD_POLL,
    B_RD_END
  } burst_t;

  typedef struct packed {
    burst_t      burst;
    logic [7:0]  data;
    logic [31:0] arg;
    logic [7:0]  crc;
    status_t     status;
    logic        cs;
  } desc_t;

  function automatic desc_t mk_desc(burst_t b, logic [7:0] d, status_t s, logic c);
    desc_t r;
    r        = '0;
    r.burst  = b;
    r.data   = d;
    r.status = s;
    r.cs     = c;
    return r;
  endfunction

  function automatic desc_t mk_cmd(logic [5:0] idx, logic [31:0] arg, logic [7:0] crc);
    desc_t r;
    r        = '0;
    r.burst  = B_CMD;
    r.data   = CMD_BASE | {2'b00, idx};
    r.arg    = arg;
    r.crc    = crc;
    r.status = ST_OK;
    return r;
  endfunction

endpackage

// File: rtl/sd_spi_host_sequencer.sv
// SD card SPI-mode host sequencer: request decode, card state, result bursts.
// Depends on sdspi_pkg.
// A beat's first result is registered in the burst descriptor, then the outputs.
// A beat with n results holds the input until the last is emitted (one result
// per cycle unless out_ready stalls); single-result beats flow at one per cycle.
// Reset (rst_n low, synchronous): phase idle, counters zero, limits 8/255/65535.
module sd_spi_host_sequencer #(
  parameter int IDLE_CLOCK_BYTES = sdspi_pkg::IDLE_CLOCK_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_block_address,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_chip_select,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sdspi_pkg::*;

  localparam int StepW = $clog2(IDLE_CLOCK_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE, PH_INIT_CLK, PH_CMD0, PH_CMD8, PH_OCR, PH_CMD55, PH_ACMD41,
    PH_RD_R1, PH_RD_TOKEN, PH_RD_DATA, PH_WR_R1, PH_WR_DATA, PH_WR_RESP
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [15:0]            attempt_r, attempt_nxt;
  logic [7:0]             poll_r, poll_nxt;
  logic [BLOCK_IDX_W-1:0] bidx_r, bidx_nxt, bidx_inc;
  logic [7:0]             r1_lim_r;
  logic [15:0]            retry_lim_r, token_lim_r;

  desc_t                  desc_r, nb;
  logic                   desc_valid_r, nb_valid;
  logic [StepW-1:0]       step_r;

  logic                   out_valid_r, out_last_r, out_cs_r;
  logic [1:0]             out_kind_r, out_status_r;
  logic [7:0]             out_byte_r;

  logic                   in_fire, emit, emit_last, cs_now;
  kind_t                  e_kind;
  logic [7:0]             e_byte;
  logic                   e_cs;
  status_t                e_st;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign emit      = desc_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !desc_valid_r || (emit && emit_last);
  assign cs_now    = (phase_r == PH_IDLE) || (phase_r == PH_INIT_CLK);
  assign bidx_inc  = bidx_r + BLOCK_IDX_W'(1);

  // Per-beat decision: next card state and the burst to emit
  always_comb begin
    phase_nxt   = phase_r;
    attempt_nxt = attempt_r;
    poll_nxt    = poll_r;
    bidx_nxt    = bidx_r;
    nb_valid    = 1'b0;
    nb          = mk_desc(B_POLL, FILL_BYTE, ST_OK, 1'b0);
    unique case (in_action)
      ACT_INIT, ACT_READ, ACT_WRITE: begin
        nb_valid = 1'b1;
        if (phase_r != PH_IDLE) begin
          nb = mk_desc(B_REJECT, 8'h00, ST_REJECT, cs_now);
        end else if (in_action == ACT_INIT) begin
          nb          = mk_desc(B_INIT, FILL_BYTE, ST_OK, 1'b1);
          attempt_nxt = '0;
          phase_nxt   = PH_INIT_CLK;
        end else begin
          poll_nxt = 8'd1;
          if (in_action == ACT_READ) begin
            phase_nxt = PH_RD_R1;
            nb = mk_cmd(CMD_READ_BLK, in_block_address, CRC_DEFAULT);
          end else begin
            phase_nxt = PH_WR_R1;
            nb = mk_cmd(CMD_WRITE_BLK, in_block_address, CRC_DEFAULT);
          end
        end
      end
      ACT_WDATA: begin
        nb_valid = 1'b1;
        if (phase_r != PH_WR_DATA) begin
          nb = mk_desc(B_REJECT, 8'h00, ST_REJECT, cs_now);
        end else begin
          bidx_nxt = bidx_inc;
          if (bidx_inc >= BLOCK_IDX_W'(BLOCK_BYTES)) begin
            nb        = mk_desc(B_WR_LAST, in_data_byte, ST_OK, 1'b0);
            phase_nxt = PH_WR_RESP;
          end else begin
            nb = mk_desc(B_DRIVE, in_data_byte, ST_OK, 1'b0);
          end
        end
      end
      ACT_REPLY: begin
        nb_valid = 1'b1;
        unique case (phase_r)
          PH_INIT_CLK: begin
            attempt_nxt = 16'd1;
            poll_nxt    = 8'd1;
            phase_nxt   = PH_CMD0;
            nb          = mk_cmd(CMD_GO_IDLE, 32'h0, CRC_DEFAULT);
          end
          PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41, PH_RD_R1, PH_WR_R1: begin
            if (((in_rx_byte & R1_BUSY_MASK) != 8'h00) && (poll_r < r1_lim_r)) begin
              poll_nxt = poll_r + 8'd1;
            end else begin
              unique case (phase_r)
                PH_CMD0: begin
                  poll_nxt = 8'd1;
                  if (in_rx_byte == R1_IDLE) begin
                    phase_nxt = PH_CMD8;
                    nb = mk_cmd(CMD_IF_COND, ARG_IF_COND, CRC_IF_COND);
                  end else if (attempt_r < retry_lim_r) begin
                    attempt_nxt = attempt_r + 16'd1;
                    nb = mk_cmd(CMD_GO_IDLE, 32'h0, CRC_DEFAULT);
                  end else begin
                    phase_nxt = PH_IDLE;
                    nb = mk_desc(B_FINISH, 8'h00, ST_ERROR, 1'b1);
                  end
                end
                PH_CMD8: begin
                  if (in_rx_byte == R1_IDLE) begin
                    bidx_nxt  = '0;
                    phase_nxt = PH_OCR;
                  end else begin
                    attempt_nxt = 16'd1;
                    poll_nxt    = 8'd1;
                    phase_nxt   = PH_CMD55;
                    nb = mk_cmd(CMD_APP, 32'h0, CRC_DEFAULT);
                  end
                end
                PH_CMD55: begin
                  poll_nxt  = 8'd1;
                  phase_nxt = PH_ACMD41;
                  nb = mk_cmd(CMD_SD_OP, ARG_SD_OP, CRC_DEFAULT);
                end
                PH_ACMD41: begin
                  if (in_rx_byte == R1_READY) begin
                    phase_nxt = PH_IDLE;
                    nb = mk_desc(B_FINISH, 8'h00, ST_OK, 1'b1);
                  end else if (attempt_r < retry_lim_r) begin
                    attempt_nxt = attempt_r + 16'd1;
                    poll_nxt    = 8'd1;
                    phase_nxt   = PH_CMD55;
                    nb = mk_cmd(CMD_APP, 32'h0, CRC_DEFAULT);
                  end else begin
                    phase_nxt = PH_IDLE;
                    nb = mk_desc(B_FINISH, 8'h00, ST_ERROR, 1'b1);
                  end
                end
                PH_RD_R1: begin
                  if (in_rx_byte != R1_READY) begin
                    phase_nxt = PH_IDLE;
                    nb = mk_desc(B_FINISH, 8'h00, ST_ERROR, 1'b1);
                  end else begin
                    attempt_nxt = 16'd1;
                    phase_nxt   = PH_RD_TOKEN;
                  end
                end
                default: begin
                  if (in_rx_byte != R1_READY) begin
                    phase_nxt = PH_IDLE;
                    nb = mk_desc(B_FINISH, 8'h00, ST_ERROR, 1'b1);
                  end else begin
                    bidx_nxt  = '0;
                    phase_nxt = PH_WR_DATA;
                    nb = mk_desc(B_DRIVE, DATA_TOKEN, ST_OK, 1'b0);
                  end
                end
              endcase
            end
          end
          PH_OCR: begin
            bidx_nxt = bidx_inc;
            if (bidx_inc >= BLOCK_IDX_W'(OCR_BYTES)) begin
              attempt_nxt = 16'd1;
              poll_nxt    = 8'd1;
              phase_nxt   = PH_CMD55;
              nb = mk_cmd(CMD_APP, 32'h0, CRC_DEFAULT);
            end
          end
          PH_RD_TOKEN: begin
            if (in_rx_byte == DATA_TOKEN) begin
              bidx_nxt  = '0;
              phase_nxt = PH_RD_DATA;
            end else if (attempt_r < token_lim_r) begin
              attempt_nxt = attempt_r + 16'd1;
            end else begin
              phase_nxt = PH_IDLE;
              nb = mk_desc(B_FINISH, 8'h00, ST_ERROR, 1'b1);
            end
          end
          PH_RD_DATA: begin
            bidx_nxt = bidx_inc;
            if (bidx_inc >= BLOCK_IDX_W'(BLOCK_BYTES)) begin
              phase_nxt = PH_IDLE;
              nb = mk_desc(B_RD_END, in_rx_byte, ST_OK, 1'b0);
            end else begin
              nb = mk_desc(B_RD_POLL, in_rx_byte, ST_OK, 1'b0);
            end
          end
          PH_WR_RESP: begin
            phase_nxt = PH_IDLE;
            nb = mk_desc(B_FINISH, 8'h00,
                         ((in_rx_byte[4:0] & RESP_MASK) == RESP_ACCEPT) ? ST_OK : ST_ERROR,
                         1'b1);
          end
          default: nb_valid = 1'b0;
        endcase
      end
      default: nb_valid = 1'b0;
    endcase
  end

  // Burst emitter: result for the current step of the held burst
  always_comb begin
    e_kind    = KIND_DRIVE;
    e_byte    = FILL_BYTE;
    e_cs      = 1'b0;
    e_st      = ST_OK;
    emit_last = 1'b1;
    unique case (desc_r.burst)
      B_REJECT, B_FINISH: begin
        e_kind = KIND_STATUS;
        e_byte = 8'h00;
        e_cs   = desc_r.cs;
        e_st   = desc_r.status;
      end
      B_INIT: begin
        e_cs      = 1'b1;
        emit_last = (step_r == StepW'(IDLE_CLOCK_BYTES - 1));
        e_kind    = emit_last ? KIND_POLL : KIND_DRIVE;
      end
      B_CMD: begin
        emit_last = (step_r == StepW'(6));
        unique case (step_r)
          StepW'(0): e_byte = desc_r.data;
          StepW'(1): e_byte = desc_r.arg[31:24];
          StepW'(2): e_byte = desc_r.arg[23:16];
          StepW'(3): e_byte = desc_r.arg[15:8];
          StepW'(4): e_byte = desc_r.arg[7:0];
          StepW'(5): e_byte = desc_r.crc;
          default:   e_kind = KIND_POLL;
        endcase
      end
      B_POLL: e_kind = KIND_POLL;
      B_DRIVE: e_byte = desc_r.data;
      B_WR_LAST: begin
        emit_last = (step_r == StepW'(3));
        if (step_r == StepW'(0)) begin
          e_byte = desc_r.data;
        end else if (emit_last) begin
          e_kind = KIND_POLL;
        end
      end
      B_RD_POLL: begin
        emit_last = (step_r == StepW'(1));
        if (emit_last) begin
          e_kind = KIND_POLL;
        end else begin
          e_kind = KIND_RDATA;
          e_byte = desc_r.data;
        end
      end
      default: begin
        emit_last = (step_r == StepW'(3));
        if (step_r == StepW'(0)) begin
          e_kind = KIND_RDATA;
          e_byte = desc_r.data;
        end else if (emit_last) begin
          e_kind = KIND_STATUS;
          e_byte = 8'h00;
          e_cs   = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      attempt_r    <= '0;
      poll_r       <= '0;
      bidx_r       <= '0;
      r1_lim_r     <= R1_POLL_RESET;
      retry_lim_r  <= INIT_RETRY_RESET;
      token_lim_r  <= TOKEN_WAIT_RESET;
      desc_valid_r <= 1'b0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_R1_POLL_LIMIT:    r1_lim_r    <= cfg_data[7:0];
          CFG_INIT_RETRY_LIMIT: retry_lim_r <= cfg_data;
          CFG_TOKEN_WAIT_LIMIT: token_lim_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_r   <= phase_nxt;
        attempt_r <= attempt_nxt;
        poll_r    <= poll_nxt;
        bidx_r    <= bidx_nxt;
      end
      if (in_fire && nb_valid) begin
        desc_r       <= nb;
        desc_valid_r <= 1'b1;
        step_r       <= '0;
      end else if (emit) begin
        if (emit_last) begin
          desc_valid_r <= 1'b0;
        end else begin
          step_r <= step_r + StepW'(1);
        end
      end
      if (emit) begin
        out_valid_r  <= 1'b1;
        out_kind_r   <= e_kind;
        out_byte_r   <= e_byte;
        out_cs_r     <= e_cs;
        out_status_r <= e_st;
        out_last_r   <= emit_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_tx_byte     = out_byte_r;
  assign out_chip_select = out_cs_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_STATUS) |-> out_last_r)
    else $error("status beat not marked last");

  a_rdata_cs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_RDATA) |-> !out_cs_r && !out_last_r)
    else $error("read data beat with chip select high or marked last");

  a_end_cs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_STATUS) && (out_status_r != ST_REJECT) |-> out_cs_r)
    else $error("ending status without chip select release");

  a_bidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    bidx_r <= BLOCK_IDX_W'(BLOCK_BYTES))
    else $error("byte index beyond block");

  a_cmd_step: assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid_r && (desc_r.burst == B_CMD) |-> step_r <= StepW'(6))
    else $error("command burst step out of range");

endmodule

// File: verif/tb_sd_spi_host_sequencer.sv
// Self-checking bench for sd_spi_host_sequencer: a directed table, then card-like
// random traffic, all bus beats checked against an in-bench host sequence model.
// Depends on sdspi_pkg and the sd_spi_host_sequencer RTL only.
`timescale 1ns / 100ps

module tb_sd_spi_host_sequencer;
  import sdspi_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SEG_BEATS     = 85;

  localparam logic [2:0] ACT_RSVD_5 = 3'd5;
  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_INIT_CLK, SQ_CMD0, SQ_CMD8, SQ_OCR, SQ_CMD55, SQ_ACMD41,
    SQ_RD_R1, SQ_RD_TOKEN, SQ_RD_DATA, SQ_WR_R1, SQ_WR_DATA, SQ_WR_RESP
  } host_phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx;
    logic       cs;
    status_t    st;
    logic       last;
  } bus_beat_t;

  typedef struct packed {
    logic [2:0]  act;
    logic [31:0] addr;
    logic [7:0]  data;
    logic [7:0]  rx;
    logic        typed;
    logic        has_beat;
    bus_beat_t   beat;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_action;
  logic [31:0] in_block_address;
  logic [7:0]  in_data_byte;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_tx_byte;
  logic        out_chip_select;
  logic [1:0]  out_status;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  sd_spi_host_sequencer uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // host sequence model state
  host_phase_t sq = SQ_IDLE;
  logic [15:0] attempts = '0;
  logic [7:0]  poll_cnt = '0;
  logic [9:0]  byte_idx = '0;
  logic [7:0]  r1_lim = R1_POLL_RESET;
  logic [15:0] init_lim = INIT_RETRY_RESET;
  logic [15:0] token_lim = TOKEN_WAIT_RESET;

  bus_beat_t pending_q[$];
  stim_row_t stim_rows[$];

  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int n_ok = 0;
  int n_err = 0;
  int n_rej = 0;
  bit req_good = 1'b1;
  bit full_rd_seen = 1'b0;
  bit full_wr_seen = 1'b0;

  function automatic void emit(kind_t k, logic [7:0] b, logic c, status_t s);
    bus_beat_t e;
    e.kind = k;
    e.tx   = b;
    e.cs   = c;
    e.st   = s;
    e.last = 1'b0;
    pending_q.push_back(e);
  endfunction

  function automatic void emit_cmd(logic [5:0] idx, logic [31:0] arg, logic [7:0] crc);
    emit(KIND_DRIVE, CMD_BASE | {2'b00, idx}, 1'b0, ST_OK);
    emit(KIND_DRIVE, arg[31:24], 1'b0, ST_OK);
    emit(KIND_DRIVE, arg[23:16], 1'b0, ST_OK);
    emit(KIND_DRIVE, arg[15:8], 1'b0, ST_OK);
    emit(KIND_DRIVE, arg[7:0], 1'b0, ST_OK);
    emit(KIND_DRIVE, crc, 1'b0, ST_OK);
    poll_cnt = 8'd1;
    emit(KIND_POLL, FILL_BYTE, 1'b0, ST_OK);
  endfunction

  function automatic void end_seq(status_t s);
    sq = SQ_IDLE;
    emit(KIND_STATUS, 8'h00, 1'b1, s);
  endfunction

  function automatic void start_app_loop();
    attempts = 16'd1;
    sq = SQ_CMD55;
    emit_cmd(CMD_APP, 32'h0, CRC_DEFAULT);
  endfunction

  // Updates the host model for one accepted beat and queues the bus beats it causes.
  function automatic int advance_host(logic [2:0] act, logic [31:0] addr, logic [7:0] data,
                                      logic [7:0] rx);
    int base;
    logic cs_now;
    base = pending_q.size();
    cs_now = (sq == SQ_IDLE || sq == SQ_INIT_CLK);
    if (act == ACT_INIT || act == ACT_READ || act == ACT_WRITE) begin
      if (sq != SQ_IDLE) begin
        emit(KIND_STATUS, 8'h00, cs_now, ST_REJECT);
      end else if (act == ACT_INIT) begin
        for (int i = 0; i < IDLE_CLOCK_BYTES - 1; i++) emit(KIND_DRIVE, FILL_BYTE, 1'b1, ST_OK);
        emit(KIND_POLL, FILL_BYTE, 1'b1, ST_OK);
        attempts = '0;
        sq = SQ_INIT_CLK;
      end else begin
        sq = (act == ACT_READ) ? SQ_RD_R1 : SQ_WR_R1;
        emit_cmd((act == ACT_READ) ? CMD_READ_BLK : CMD_WRITE_BLK, addr, CRC_DEFAULT);
      end
    end else if (act == ACT_WDATA) begin
      if (sq != SQ_WR_DATA) begin
        emit(KIND_STATUS, 8'h00, cs_now, ST_REJECT);
      end else begin
        emit(KIND_DRIVE, data, 1'b0, ST_OK);
        byte_idx++;
        if (byte_idx >= BLOCK_BYTES) begin
          emit(KIND_DRIVE, FILL_BYTE, 1'b0, ST_OK);
          emit(KIND_DRIVE, FILL_BYTE, 1'b0, ST_OK);
          emit(KIND_POLL, FILL_BYTE, 1'b0, ST_OK);
          sq = SQ_WR_RESP;
        end
      end
    end else if (act == ACT_REPLY && sq != SQ_IDLE && sq != SQ_WR_DATA) begin
      case (sq)
        SQ_INIT_CLK: begin
          attempts = 16'd1;
          sq = SQ_CMD0;
          emit_cmd(CMD_GO_IDLE, 32'h0, CRC_DEFAULT);
        end
        SQ_OCR: begin
          byte_idx++;
          if (byte_idx < OCR_BYTES) emit(KIND_POLL, FILL_BYTE, 1'b0, ST_OK);
          else start_app_loop();
        end
        SQ_RD_TOKEN: begin
          if (rx == DATA_TOKEN) begin
            byte_idx = '0;
            sq = SQ_RD_DATA;
            emit(KIND_POLL, FILL_BYTE, 1'b0, ST_OK);
          end else if (attempts < token_lim) begin
            attempts++;
            emit(KIND_POLL, FILL_BYTE, 1'b0, ST_OK);
          end else begin
            end_seq(ST_ERROR);
          end
        end
        SQ_RD_DATA: begin
          emit(KIND_RDATA, rx, 1'b0, ST_OK);
          byte_idx++;
          if (byte_idx < BLOCK_BYTES) begin
            emit(KIND_POLL, FILL_BYTE, 1'b0, ST_OK);
          end else begin
            emit(KIND_DRIVE, FILL_BYTE, 1'b0, ST_OK);
            emit(KIND_DRIVE, FILL_BYTE, 1'b0, ST_OK);
            end_seq(ST_OK);
          end
        end
        SQ_WR_RESP: end_seq((rx[4:0] == RESP_ACCEPT) ? ST_OK : ST_ERROR);
        default: begin
          // command reply phases: poll again while busy and under the poll limit, else take R1
          if ((rx & R1_BUSY_MASK) != 8'h00 && poll_cnt < r1_lim) begin
            poll_cnt++;
            emit(KIND_POLL, FILL_BYTE, 1'b0, ST_OK);
          end else begin
            case (sq)
              SQ_CMD0: begin
                if (rx == R1_IDLE) begin
                  sq = SQ_CMD8;
                  emit_cmd(CMD_IF_COND, ARG_IF_COND, CRC_IF_COND);
                end else if (attempts < init_lim) begin
                  attempts++;
                  emit_cmd(CMD_GO_IDLE, 32'h0, CRC_DEFAULT);
                end else begin
                  end_seq(ST_ERROR);
                end
              end
              SQ_CMD8: begin
                if (rx == R1_IDLE) begin
                  byte_idx = '0;
                  sq = SQ_OCR;
                  emit(KIND_POLL, FILL_BYTE, 1'b0, ST_OK);
                end else begin
                  start_app_loop();
                end
              end
              SQ_CMD55: begin
                sq = SQ_ACMD41;
                emit_cmd(CMD_SD_OP, ARG_SD_OP, CRC_DEFAULT);
              end
              SQ_ACMD41: begin
                if (rx == R1_READY) begin
                  end_seq(ST_OK);
                end else if (attempts < init_lim) begin
                  attempts++;
                  sq = SQ_CMD55;
                  emit_cmd(CMD_APP, 32'h0, CRC_DEFAULT);
                end else begin
                  end_seq(ST_ERROR);
                end
              end
              SQ_RD_R1: begin
                if (rx != R1_READY) begin
                  end_seq(ST_ERROR);
                end else begin
                  attempts = 16'd1;
                  sq = SQ_RD_TOKEN;
                  emit(KIND_POLL, FILL_BYTE, 1'b0, ST_OK);
                end
              end
              default: begin
                if (rx != R1_READY) begin
                  end_seq(ST_ERROR);
                end else begin
                  byte_idx = '0;
                  sq = SQ_WR_DATA;
                  emit(KIND_DRIVE, DATA_TOKEN, 1'b0, ST_OK);
                end
              end
            endcase
          end
        end
      endcase
    end
    if (pending_q.size() > base) pending_q[pending_q.size() - 1].last = 1'b1;
    return pending_q.size() - base;
  endfunction

  // Plays the card and the user: picks the next beat from the host model's phase.
  function automatic void pick_item(output logic [2:0] a, output logic [31:0] ad,
                                    output logic [7:0] d, output logic [7:0] r);
    logic [7:0] want;
    a  = ACT_REPLY;
    ad = $urandom;
    d  = 8'($urandom);
    r  = 8'($urandom);
    if ($urandom_range(3) == 0) ad = ($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
    if ($urandom_range(99) < 6) begin
      a = 3'($urandom_range(7));
      return;
    end
    case (sq)
      SQ_IDLE: begin
        case ($urandom_range(2))
          0: a = ACT_INIT;
          1: begin
            a = ACT_READ;
            req_good = !full_rd_seen || $urandom_range(5) == 0;
            full_rd_seen = full_rd_seen | req_good;
          end
          default: begin
            a = ACT_WRITE;
            req_good = !full_wr_seen || $urandom_range(5) == 0;
            full_wr_seen = full_wr_seen | req_good;
          end
        endcase
      end
      SQ_WR_DATA: a = ACT_WDATA;
      SQ_CMD0, SQ_CMD8, SQ_CMD55, SQ_ACMD41, SQ_RD_R1, SQ_WR_R1: begin
        want = (sq == SQ_CMD0 || sq == SQ_CMD8) ? R1_IDLE : R1_READY;
        if ($urandom_range(3) == 0) begin
          r = r | R1_BUSY_MASK;
        end else if ((sq == SQ_RD_R1 || sq == SQ_WR_R1) && !req_good) begin
          if (r == want) r = r ^ 8'h02;
        end else if (sq == SQ_CMD55 || (sq == SQ_CMD8 && $urandom_range(1) == 0)) begin
          r = r & ~R1_BUSY_MASK;
        end else if ((sq == SQ_CMD0 || sq == SQ_ACMD41) && $urandom_range(3) == 0) begin
          r = r & ~R1_BUSY_MASK;
          if (r == want) r = r ^ 8'h04;
        end else begin
          r = want;
        end
      end
      SQ_RD_TOKEN: begin
        if (attempts < token_lim && $urandom_range(1) == 0) begin
          if (r == DATA_TOKEN) r = r ^ 8'h01;
        end else begin
          r = DATA_TOKEN;
        end
      end
      SQ_WR_RESP: if ($urandom_range(3) != 0) r = {r[7:5], RESP_ACCEPT};
      default: ;
    endcase
  endfunction

  function automatic bus_beat_t status_beat(logic c, status_t s);
    bus_beat_t b;
    b.kind = KIND_STATUS;
    b.tx   = 8'h00;
    b.cs   = c;
    b.st   = s;
    b.last = 1'b1;
    return b;
  endfunction

  function automatic void add_row(logic [2:0] a, logic [31:0] ad, logic [7:0] d, logic [7:0] r,
                                  logic typed, logic has, bus_beat_t b);
    stim_row_t s;
    s.act = a;
    s.addr = ad;
    s.data = d;
    s.rx = r;
    s.typed = typed;
    s.has_beat = has;
    s.beat = b;
    stim_rows.push_back(s);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input logic [2:0] a, input logic [31:0] ad, input logic [7:0] d,
                           input logic [7:0] r, output int produced);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = a;
    in_block_address = ad;
    in_data_byte = d;
    in_rx_byte = r;
    do @(posedge clk); while (!in_ready);
    produced = advance_host(a, ad, d, r);
    if (produced > 0) beats_in++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_R1_POLL_LIMIT:    r1_lim = val[7:0];
      CFG_INIT_RETRY_LIMIT: init_lim = val;
      default:              token_lim = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) out_ready = ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bus beats still owed", $time, pending_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    bus_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (out_kind == KIND_STATUS) begin
        if (out_status == ST_OK) n_ok++;
        else if (out_status == ST_ERROR) n_err++;
        else n_rej++;
      end
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat kind %0d byte %h cs %b status %0d last %b", $time,
                 out_kind, out_tx_byte, out_chip_select, out_status, out_last);
      end else begin
        want = pending_q.pop_front();
        if (out_kind !== want.kind || out_tx_byte !== want.tx || out_chip_select !== want.cs ||
            out_status !== want.st || out_last !== want.last) begin
          errors++;
          $display("%0t: beat mismatch exp kind %0d byte %h cs %b status %0d last %b", $time,
                   want.kind, want.tx, want.cs, want.st, want.last);
          $display("%0t:                got kind %0d byte %h cs %b status %0d last %b", $time,
                   out_kind, out_tx_byte, out_chip_select, out_status, out_last);
        end
      end
    end
  end

  initial begin
    logic [2:0]  a;
    logic [31:0] ad;
    logic [7:0]  d;
    logic [7:0]  r;
    int          n;
    stim_row_t   rw;
    bus_beat_t   none;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_INIT;
    in_block_address = '0;
    in_data_byte = '0;
    in_rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_R1_POLL_LIMIT;
    cfg_data = '0;
    none = '0;

    // idle misuse, then a read and a write failing on R1, then init up to the app loop
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'hFF, 1'b1, 1'b0, none);
    add_row(ACT_WDATA, 32'h0, 8'hA5, 8'h00, 1'b1, 1'b1, status_beat(1'b1, ST_REJECT));
    add_row(ACT_RSVD_5, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, 1'b0, none);
    add_row(ACT_RSVD_6, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, 1'b0, none);
    add_row(ACT_RSVD_7, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, 1'b0, none);
    add_row(ACT_READ, 32'hFFFF_FFFF, 8'h00, 8'h00, 1'b0, 1'b0, none);
    add_row(ACT_INIT, 32'h0, 8'h00, 8'h00, 1'b1, 1'b1, status_beat(1'b0, ST_REJECT));
    add_row(ACT_WRITE, 32'h0, 8'h00, 8'h00, 1'b1, 1'b1, status_beat(1'b0, ST_REJECT));
    add_row(ACT_WDATA, 32'h0, 8'h00, 8'h00, 1'b1, 1'b1, status_beat(1'b0, ST_REJECT));
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'h80, 1'b0, 1'b0, none);
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'h7F, 1'b1, 1'b1, status_beat(1'b1, ST_ERROR));
    add_row(ACT_WRITE, 32'h0, 8'h00, 8'h00, 1'b0, 1'b0, none);
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'hFF, 1'b0, 1'b0, none);
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'h01, 1'b1, 1'b1, status_beat(1'b1, ST_ERROR));
    add_row(ACT_INIT, 32'h0, 8'h00, 8'h00, 1'b0, 1'b0, none);
    add_row(ACT_READ, 32'h0, 8'h00, 8'h00, 1'b1, 1'b1, status_beat(1'b1, ST_REJECT));
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'h00, 1'b0, 1'b0, none);
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'h00, 1'b0, 1'b0, none);
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'h01, 1'b0, 1'b0, none);
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'h01, 1'b0, 1'b0, none);
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'hAA, 1'b0, 1'b0, none);
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'h55, 1'b0, 1'b0, none);
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'h00, 1'b0, 1'b0, none);
    add_row(ACT_REPLY, 32'h0, 8'h00, 8'hFF, 1'b0, 1'b0, none);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle = 33;
    recv_idle = 48;
    foreach (stim_rows[i]) begin
      rw = stim_rows[i];
      send_beat(rw.act, rw.addr, rw.data, rw.rx, n);
      if (rw.typed) begin
        repeat (n) void'(pending_q.pop_back());
        if (rw.has_beat) pending_q.push_back(rw.beat);
      end
    end

    for (int seg = 0; seg < 4; seg++) begin
      if (seg > 0) begin
        wait_drained();
        case (seg)
          1: begin
            write_reg(CFG_R1_POLL_LIMIT, 16'd0);
            write_reg(CFG_INIT_RETRY_LIMIT, 16'd0);
            write_reg(CFG_TOKEN_WAIT_LIMIT, 16'd0);
          end
          2: begin
            write_reg(CFG_TOKEN_WAIT_LIMIT, 16'hFFFF);
            write_reg(CFG_R1_POLL_LIMIT, 16'd255);
            write_reg(CFG_INIT_RETRY_LIMIT, 16'hFFFF);
          end
          default: begin
            write_reg(CFG_INIT_RETRY_LIMIT, 16'($urandom_range(3, 1)));
            write_reg(CFG_TOKEN_WAIT_LIMIT, 16'($urandom_range(6, 1)));
            write_reg(CFG_R1_POLL_LIMIT, 16'($urandom_range(4, 1)));
          end
        endcase
      end
      send_idle = (seg == 0) ? 33 : (seg == 1) ? 48 : 0;
      recv_idle = (seg == 0) ? 48 : (seg == 1) ? 33 : 0;
      n = 0;
      for (int k = 0; k < SEG_BEATS || sq != SQ_IDLE; k += (n > 0)) begin
        if ($urandom_range(99) < 3) begin
          in_valid = 1'b0;
          while (pending_q.size() != 0) @(negedge clk);
        end
        pick_item(a, ad, d, r);
        send_beat(a, ad, d, r, n);
      end
    end

    wait_drained();
    $display("covered %0d input beats and %0d bus beats in %0d cycles, four limit settings",
             beats_in, beats_out, cycles);
    $display("status beats: %0d ok, %0d card error or timeout, %0d rejected",
             n_ok, n_err, n_rej);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
